// File: hdl/trr_pkg.sv
// ----------------------------------------------------------------------------
// trr_pkg
// Shared widths, constants and types of the tagged register replica.
// ----------------------------------------------------------------------------
package trr_pkg;

	localparam int CLIENT_SLOTS_DEF = 16;

	localparam int ID_W     = 16;
	localparam int TIME_W   = 31;
	localparam int WRITER_W = 16;
	localparam int VALUE_W  = 32;
	localparam int REQ_W    = 31;
	localparam int ROLL_W   = 7;

	localparam int IN_DATA_W  = 136;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 128;
	localparam int OUT_USER_W = 1;

	localparam logic [ROLL_W-1:0]  THRESH_RESET = 7'd100;
	localparam logic [VALUE_W-1:0] VALUE_RESET  = '1;

	localparam logic MODE_MESSAGE = 1'b0;
	localparam logic MODE_CLOSE   = 1'b1;

	// one client table entry
	typedef struct packed {
		logic [ID_W-1:0]  client;
		logic [REQ_W-1:0] last;
	} trr_entry_t;

endpackage

// File: hdl/trr_slot_table.sv
// ----------------------------------------------------------------------------
// trr_slot_table
// Client table: entry memory with one write and one registered read port,
// plus a valid flag per slot that reset clears.
// ----------------------------------------------------------------------------
module trr_slot_table
	import trr_pkg::*;
#(
	parameter int CLIENT_SLOTS = CLIENT_SLOTS_DEF,
	localparam int IDX_W = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output trr_entry_t       rd_entry,
	output logic             rd_valid,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  trr_entry_t       wr_entry,
	input  logic             clr_en,
	input  logic [IDX_W-1:0] clr_addr
);

	trr_entry_t                mem_q [CLIENT_SLOTS];
	logic [CLIENT_SLOTS-1:0]   valid_q;
	trr_entry_t                rd_entry_q;
	logic                      rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_entry_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (clr_en) begin
				valid_q[clr_addr] <= 1'b0;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_entry = rd_entry_q;
	assign rd_valid = rd_valid_q;

endmodule

// File: hdl/tagged_register_replica.sv
// ----------------------------------------------------------------------------
// tagged_register_replica
// Server replica of a multi-writer register: client table, tag check and
// acknowledge generation.
// ----------------------------------------------------------------------------
// One input word is taken at a time. The client table is walked one slot per
// cycle through its single read port. A message from a new client is then
// registered in a free slot, if the scan found one, before the decision; a
// close returns to idle straight after the scan. The decision waits while an
// earlier ack still sits in the output register. A rejected message and a
// close give no ack.
// ----------------------------------------------------------------------------
module tagged_register_replica
	import trr_pkg::*;
#(
	parameter int CLIENT_SLOTS = CLIENT_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// client_id, tag_time, tag_writer, data_value, request_number, fail_roll
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// mode, first_in_connection, is_write
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// ack_client, ack_request, held_time, held_writer, held_value
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// ack_is_write
	output logic [OUT_USER_W-1:0] m_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic                  cfg_we,
	input  logic [ROLL_W-1:0]     cfg_wdata
);

	localparam int IDX_W = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
	localparam int CNT_W = $clog2(CLIENT_SLOTS + 1);
	localparam logic [CNT_W-1:0] CNT_END = CNT_W'(CLIENT_SLOTS);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_REG    = 4'b0100,
		ST_DECIDE = 4'b1000
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 rd_vld_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 match_hit_q;
	logic [IDX_W-1:0]     match_idx_q;
	logic [REQ_W-1:0]     match_last_q;
	logic                 free_hit_q;
	logic [IDX_W-1:0]     free_idx_q;
	logic [ROLL_W-1:0]    thresh_q;

	// latched input word
	logic                 mode_q;
	logic                 first_q;
	logic                 is_write_q;
	logic [ID_W-1:0]      id_q;
	logic [TIME_W-1:0]    ttime_q;
	logic [WRITER_W-1:0]  twriter_q;
	logic [VALUE_W-1:0]   value_q;
	logic [REQ_W-1:0]     req_q;
	logic [ROLL_W-1:0]    roll_q;

	logic [TIME_W-1:0]    stored_time_q;
	logic [WRITER_W-1:0]  stored_writer_q;
	logic [VALUE_W-1:0]   stored_value_q;

	logic                 out_vld_q;
	logic                 out_is_write_q;
	logic [ID_W-1:0]      out_client_q;
	logic [REQ_W-1:0]     out_req_q;
	logic [TIME_W-1:0]    out_time_q;
	logic [WRITER_W-1:0]  out_writer_q;
	logic [VALUE_W-1:0]   out_value_q;

	logic                 in_acc;
	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	trr_entry_t           rd_entry;
	logic                 rd_valid;
	logic                 tbl_wr_en;
	logic [IDX_W-1:0]     tbl_wr_addr;
	trr_entry_t           tbl_wr_entry;
	logic                 tbl_clr_en;
	logic                 scan_done;
	logic                 hit_now;
	logic                 free_now;
	logic                 take_free;
	logic                 use_free;
	logic                 out_room;
	logic                 accept;
	logic                 greater;
	logic                 out_load;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign rd_en     = (state_q == ST_SCAN) && (cnt_q != CNT_END);
	assign rd_addr   = cnt_q[IDX_W-1:0];
	assign scan_done = (state_q == ST_SCAN) && (cnt_q == CNT_END) && !rd_vld_s1;

	// shared compare on the slot just read
	assign hit_now  = rd_vld_s1 && rd_valid && (rd_entry.client == id_q) && (id_q != '0);
	assign free_now = rd_vld_s1 && !rd_valid;

	assign take_free = first_q && (id_q != '0) && free_hit_q;
	// the new slot wins lookup unless an older copy sits lower in the table
	assign use_free  = !match_hit_q || (free_idx_q < match_idx_q);

	assign out_room = !out_vld_q || m_axis_tready;
	assign accept   = (req_q >= match_last_q) && (roll_q < thresh_q);
	assign greater  = (ttime_q > stored_time_q) ||
	                  ((ttime_q == stored_time_q) && (twriter_q > stored_writer_q));
	assign out_load = (state_q == ST_DECIDE) && out_room && accept;

	always_comb begin
		tbl_wr_en    = 1'b0;
		tbl_wr_addr  = match_idx_q;
		tbl_wr_entry = '{client: id_q, last: req_q};
		if (state_q == ST_REG) begin
			tbl_wr_en    = 1'b1;
			tbl_wr_addr  = free_idx_q;
			tbl_wr_entry = '{client: id_q, last: '0};
		end else if (out_load && match_hit_q) begin
			tbl_wr_en = 1'b1;
		end
	end

	assign tbl_clr_en = scan_done && (mode_q == MODE_CLOSE) && match_hit_q;

	trr_slot_table #(
		.CLIENT_SLOTS(CLIENT_SLOTS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry),
		.rd_valid (rd_valid),
		.wr_en    (tbl_wr_en),
		.wr_addr  (tbl_wr_addr),
		.wr_entry (tbl_wr_entry),
		.clr_en   (tbl_clr_en),
		.clr_addr (match_idx_q)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			cnt_q           <= '0;
			rd_vld_s1       <= 1'b0;
			match_hit_q     <= 1'b0;
			free_hit_q      <= 1'b0;
			thresh_q        <= THRESH_RESET;
			stored_time_q   <= '0;
			stored_writer_q <= '0;
			stored_value_q  <= VALUE_RESET;
			out_vld_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				thresh_q <= cfg_wdata;
			end
			rd_vld_s1 <= rd_en;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cnt_q       <= '0;
						match_hit_q <= 1'b0;
						free_hit_q  <= 1'b0;
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (hit_now && !match_hit_q) begin
						match_hit_q <= 1'b1;
					end
					if (free_now && !free_hit_q) begin
						free_hit_q <= 1'b1;
					end
					if (scan_done) begin
						if (mode_q == MODE_CLOSE) begin
							state_q <= ST_IDLE;
						end else if (take_free) begin
							state_q <= ST_REG;
						end else begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_REG: begin
					if (use_free) begin
						match_hit_q <= 1'b1;
					end
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (out_load && greater) begin
						stored_time_q   <= ttime_q;
						stored_writer_q <= twriter_q;
						stored_value_q  <= value_q;
					end
					if (out_room) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			first_q      <= s_axis_tuser[1];
			mode_q       <= s_axis_tuser[0];
			is_write_q   <= s_axis_tuser[2];
			id_q         <= s_axis_tdata[15:0];
			ttime_q      <= s_axis_tdata[46:16];
			twriter_q    <= s_axis_tdata[62:47];
			value_q      <= s_axis_tdata[94:63];
			req_q        <= s_axis_tdata[125:95];
			roll_q       <= s_axis_tdata[132:126];
			match_last_q <= '0;
		end
		idx_s1 <= rd_addr;
		if ((state_q == ST_SCAN) && hit_now && !match_hit_q) begin
			match_idx_q  <= idx_s1;
			match_last_q <= rd_entry.last;
		end
		if ((state_q == ST_SCAN) && free_now && !free_hit_q) begin
			free_idx_q <= idx_s1;
		end
		if ((state_q == ST_REG) && use_free) begin
			match_idx_q  <= free_idx_q;
			match_last_q <= '0;
		end
		if (out_load) begin
			out_is_write_q <= is_write_q;
			out_client_q   <= id_q;
			out_req_q      <= req_q;
			out_time_q     <= greater ? ttime_q : stored_time_q;
			out_writer_q   <= greater ? twriter_q : stored_writer_q;
			out_value_q    <= greater ? value_q : stored_value_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_is_write_q;
	assign m_axis_tdata  = {2'b00, out_value_q, out_writer_q, out_time_q, out_req_q,
	                        out_client_q};

	// no table write while the scan is reading it
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (!tbl_wr_en && !out_load))
		else $error("table written during scan");

	// a found slot always lies inside the table
	a_match_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DECIDE) && match_hit_q) |->
			(32'(match_idx_q) < 32'(CLIENT_SLOTS)))
		else $error("slot index beyond table");

	// registration leaves the decision with a slot to update
	a_reg_gives_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REG) |=> (match_hit_q && (state_q == ST_DECIDE)))
		else $error("registration lost its slot");

	// a new ack never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_axis_tvalid || m_axis_tready))
		else $error("ack overwritten");

endmodule
